// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// Every macro expands to a labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active low).
`define SEUD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked across reset.
`define SEUD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- rtl/core/seud_pkg.sv -----
// Shared types, constants and helper functions of the string unescape block.
// No dependencies; used by seud_dp, seud_ctrl and the top level.
`timescale 1ns / 1ps

package seud_pkg;

  // Default number of hex digits allowed inside \u{...}.
  localparam int MAX_HEX_DIGITS = 8;

  // Width of the per-transaction result index and count; covers brace, up to
  // sixteen digits and one trailing plain byte.
  localparam int IDX_W = 5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_BYTE,
    KIND_UTF8,
    KIND_REPLAY
  } emit_kind_e;

  // Datapath -> controller: result count of the byte on the input port.
  typedef struct packed {
    logic [IDX_W-1:0] len;
    logic             last;
  } dp_status_t;

  // Controller -> datapath.
  typedef struct packed {
    logic             accept;
    logic             load;
    logic [IDX_W-1:0] idx;
    logic             mark;
  } dp_cmd_t;

  // Number of UTF-8 bytes for a code value.
  function automatic logic [2:0] utf8_len(input logic [31:0] cp);
    logic [2:0] n;
    if (cp <= 32'h0000_007F) begin
      n = 3'd1;
    end else if (cp <= 32'h0000_07FF) begin
      n = 3'd2;
    end else if (cp <= 32'h0000_FFFF) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/string_escape_utf8_decoder.sv -----
// String literal unescaper: raw literal bytes in, decoded UTF-8 bytes out.
// Top level; instantiates seud_ctrl and seud_dp, uses seud_pkg.
//
// Input channel (in_valid_i / in_stall_o): one raw byte per transaction,
// in_last_i marks the final byte of the literal. Output channel
// (res_valid_o / res_stall_i): one result per transaction with out_byte_o,
// out_valid_o (0 on a bare end marker) and out_last_o.
// Sequencing: an input transaction is taken while the sequencer is idle; its
// results then leave the output register one per cycle while the receiver does
// not stall, the first once the sequencer has entered its emit state. A closed
// \u{...} gives up to 4 result bytes, a failed escape up to MaxHexDigits + 2.
// in_stall_o stays high while the results of a transaction are being sequenced.
// Reset (rst_ni low, asynchronous) returns the parser to seeking the opening
// quote and empties the output register. When the receiver stalls, the output
// register holds its result and the sequencer waits; a new input is taken as
// soon as the last result of the previous one is loaded.
`timescale 1ns / 1ps

module string_escape_utf8_decoder #(
  parameter int MaxHexDigits = seud_pkg::MAX_HEX_DIGITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       out_last_o
);

  // Command and status between sequencer and datapath.
  seud_pkg::dp_cmd_t    cmd;
  seud_pkg::dp_status_t status;

  // Sequencer: take input, walk the result index, drive output valid and last.
  seud_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .out_last_o  (out_last_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: parse state, hex accumulator, digit buffer, result byte.
  seud_dp #(
    .MaxHexDigits (MaxHexDigits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o)
  );

endmodule

// ----- rtl/core/seud_dp.sv -----
// Datapath: parse mode, hex accumulator, digit buffer and result byte register.
// Depends on seud_pkg; driven by seud_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module seud_dp #(
  parameter int MaxHexDigits = seud_pkg::MAX_HEX_DIGITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  seud_pkg::dp_cmd_t    cmd_i,
  output seud_pkg::dp_status_t status_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_valid_o
);

  localparam int CNT_W   = $clog2(MaxHexDigits + 1);
  localparam int PEND_AW = $clog2(MaxHexDigits);
  localparam int IDX_W   = seud_pkg::IDX_W;

  localparam logic [2:0] MODE_SEEK  = 3'd0;
  localparam logic [2:0] MODE_TEXT  = 3'd1;
  localparam logic [2:0] MODE_ESC   = 3'd2;
  localparam logic [2:0] MODE_UOPEN = 3'd3;
  localparam logic [2:0] MODE_HEX   = 3'd4;

  logic [2:0]             mode_q, mode_d;
  logic [31:0]            code_q, code_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [7:0]             pend_q [MaxHexDigits];
  seud_pkg::emit_kind_e   kind_q, kind_d;
  logic [7:0]             val_q, val_d;
  logic [7:0]             out_byte_q, out_byte_d;
  logic                   out_vld_q, out_vld_d;

  logic                   pend_we;
  logic                   tail;
  logic                   is_bs;
  logic                   hex_ok;
  logic [3:0]             hex_v;
  logic                   esc_hit;
  logic [7:0]             esc_v;

  // Hex digit decode.
  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (in_byte_i inside {[8'h30:8'h39]}) begin
      hex_v = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i inside {[8'h61:8'h66]}) begin
      hex_v = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i inside {[8'h41:8'h46]}) begin
      hex_v = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Single-character escapes.
  always_comb begin
    esc_hit = 1'b1;
    case (in_byte_i)
      8'h6E:   esc_v = 8'h0A;
      8'h74:   esc_v = 8'h09;
      8'h72:   esc_v = 8'h0D;
      8'h61:   esc_v = 8'h07;
      8'h62:   esc_v = 8'h08;
      8'h66:   esc_v = 8'h0C;
      8'h76:   esc_v = 8'h0B;
      8'h30:   esc_v = 8'h00;
      seud_pkg::CH_BSLASH: esc_v = seud_pkg::CH_BSLASH;
      seud_pkg::CH_APOS:   esc_v = seud_pkg::CH_APOS;
      seud_pkg::CH_QUOTE:  esc_v = seud_pkg::CH_QUOTE;
      default: begin
        esc_hit = 1'b0;
        esc_v   = 8'h00;
      end
    endcase
  end

  assign is_bs = (in_byte_i == seud_pkg::CH_BSLASH);

  // Parse step for the byte on the input port.
  always_comb begin
    mode_d  = mode_q;
    code_d  = code_q;
    cnt_d   = cnt_q;
    kind_d  = seud_pkg::KIND_NONE;
    val_d   = in_byte_i;
    pend_we = 1'b0;
    tail    = 1'b0;
    case (mode_q)
      MODE_SEEK: begin
        if (!in_last_i && in_byte_i == seud_pkg::CH_QUOTE) mode_d = MODE_TEXT;
      end
      MODE_TEXT: begin
        if (!in_last_i) begin
          if (is_bs) mode_d = MODE_ESC;
          else kind_d = seud_pkg::KIND_BYTE;
        end
      end
      MODE_ESC: begin
        mode_d = MODE_TEXT;
        if (esc_hit) begin
          kind_d = seud_pkg::KIND_BYTE;
          val_d  = esc_v;
        end else if (in_byte_i == seud_pkg::CH_LOW_U && !in_last_i) begin
          mode_d = MODE_UOPEN;
        end
      end
      MODE_UOPEN: begin
        if (in_byte_i == seud_pkg::CH_LBRACE && !in_last_i) begin
          mode_d = MODE_HEX;
          code_d = 32'd0;
          cnt_d  = '0;
        end else begin
          mode_d = MODE_TEXT;
          if (!in_last_i) begin
            if (is_bs) mode_d = MODE_ESC;
            else kind_d = seud_pkg::KIND_BYTE;
          end
        end
      end
      MODE_HEX: begin
        if (in_byte_i == seud_pkg::CH_RBRACE && cnt_q != '0) begin
          kind_d = seud_pkg::KIND_UTF8;
          mode_d = MODE_TEXT;
        end else if (hex_ok && !in_last_i && cnt_q < CNT_W'(MaxHexDigits)) begin
          pend_we = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
          code_d  = {code_q[27:0], hex_v};
        end else begin
          // Failed escape: replay brace and digits, then the byte as text unless it is the final byte or a backslash.
          kind_d = seud_pkg::KIND_REPLAY;
          mode_d = MODE_TEXT;
          if (!in_last_i) begin
            if (is_bs) mode_d = MODE_ESC;
            else tail = 1'b1;
          end
        end
      end
      default: mode_d = MODE_SEEK;
    endcase
    if (in_last_i) mode_d = MODE_SEEK;
  end

  always_comb begin
    status_o.last = in_last_i;
    case (kind_d)
      seud_pkg::KIND_BYTE:   status_o.len = IDX_W'(1);
      seud_pkg::KIND_UTF8:   status_o.len = IDX_W'(seud_pkg::utf8_len(code_q));
      seud_pkg::KIND_REPLAY: status_o.len = IDX_W'(cnt_q) + IDX_W'(1) + IDX_W'(tail);
      default:               status_o.len = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEEK;
      code_q <= 32'd0;
      cnt_q  <= '0;
    end else if (cmd_i.accept) begin
      mode_q <= mode_d;
      code_q <= code_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_d;
      val_q  <= val_d;
      if (pend_we) pend_q[cnt_q[PEND_AW-1:0]] <= in_byte_i;
    end
  end

  // Result byte selection for the current index.
  logic [2:0]         u_len;
  logic [1:0]         u_sh;
  logic [7:0]         u_lead;
  logic [5:0]         u_six;
  logic [IDX_W-1:0]   p_idx;

  assign u_len = seud_pkg::utf8_len(code_q);
  assign u_sh  = 2'(u_len - 3'd1 - cmd_i.idx[2:0]);
  assign p_idx = cmd_i.idx - IDX_W'(1);

  always_comb begin
    case (u_len)
      3'd1:    u_lead = code_q[7:0];
      3'd2:    u_lead = {3'b110, code_q[10:6]};
      3'd3:    u_lead = {4'b1110, code_q[15:12]};
      default: u_lead = 8'hF0 | code_q[25:18];
    endcase
    case (u_sh)
      2'd0:    u_six = code_q[5:0];
      2'd1:    u_six = code_q[11:6];
      2'd2:    u_six = code_q[17:12];
      default: u_six = code_q[23:18];
    endcase
  end

  always_comb begin
    out_vld_d  = 1'b1;
    out_byte_d = val_q;
    if (cmd_i.mark) begin
      out_vld_d  = 1'b0;
      out_byte_d = 8'h00;
    end else begin
      case (kind_q)
        seud_pkg::KIND_UTF8: begin
          out_byte_d = (cmd_i.idx == '0) ? u_lead : {2'b10, u_six};
        end
        seud_pkg::KIND_REPLAY: begin
          if (cmd_i.idx == '0) out_byte_d = seud_pkg::CH_LBRACE;
          else if (cmd_i.idx <= IDX_W'(cnt_q)) out_byte_d = pend_q[p_idx[PEND_AW-1:0]];
          else out_byte_d = val_q;
        end
        default: out_byte_d = val_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q <= out_byte_d;
      out_vld_q  <= out_vld_d;
    end
  end

  assign out_byte_o  = out_byte_q;
  assign out_valid_o = out_vld_q;

endmodule

// ----- rtl/core/seud_ctrl.sv -----
// Controller: input handshake, result sequencing and output valid/last.
// Depends on seud_pkg; commands seud_dp through dp_cmd_t.
`timescale 1ns / 1ps

module seud_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 res_valid_o,
  input  logic                 res_stall_i,
  output logic                 out_last_o,
  input  seud_pkg::dp_status_t status_i,
  output seud_pkg::dp_cmd_t    cmd_o
);

  localparam int IDX_W = seud_pkg::IDX_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] len_q, len_d;
  logic             mark_q, mark_d;
  logic             last_q, last_d;
  logic             res_valid_q, res_valid_d;
  logic             out_last_q, out_last_d;

  logic accept;
  logic load;
  logic final_idx;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign load      = (state_q == ST_EMIT) && (!res_valid_q || !res_stall_i);
  assign final_idx = (idx_q == len_q - IDX_W'(1));

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    len_d      = len_q;
    mark_d     = mark_q;
    last_d     = last_q;
    out_last_d = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (status_i.len != '0 || status_i.last)) begin
          state_d = ST_EMIT;
          idx_d   = '0;
          mark_d  = (status_i.len == '0);
          len_d   = (status_i.len == '0) ? IDX_W'(1) : status_i.len;
          last_d  = status_i.last;
        end
      end
      ST_EMIT: begin
        if (load) begin
          idx_d      = idx_q + IDX_W'(1);
          out_last_d = last_q && final_idx;
          if (final_idx) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load) res_valid_d = 1'b1;
    else if (!res_stall_i) res_valid_d = 1'b0;
    else res_valid_d = res_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      len_q       <= '0;
      mark_q      <= 1'b0;
      last_q      <= 1'b0;
      res_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      mark_q      <= mark_d;
      last_q      <= last_d;
      res_valid_q <= res_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign out_last_o  = out_last_q;

  assign cmd_o.accept = accept;
  assign cmd_o.load   = load;
  assign cmd_o.idx    = idx_q;
  assign cmd_o.mark   = mark_q;

endmodule

// ----- rtl/core/seud_checker.sv -----
// Port-level checker for string_escape_utf8_decoder, attached with bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module seud_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       in_last_i,
  input logic       res_valid_o,
  input logic       res_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_valid_o,
  input logic       out_last_o
);

  // Hold a stalled result.
  `SEUD_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_o && res_stall_i |=> res_valid_o && $stable(out_byte_o) && $stable(out_valid_o) && $stable(out_last_o))

  // A bare end marker carries a zero byte and closes the literal.
  `SEUD_ASSERT(a_bare_mark, clk_i, rst_ni, res_valid_o && !out_valid_o |-> out_last_o && out_byte_o == 8'h00)

  // A final byte always yields at least one result, so input stalls next.
  `SEUD_ASSERT(a_last_emits, clk_i, rst_ni, in_valid_i && !in_stall_o && in_last_i |=> in_stall_o)

  // No result is shown while reset is held.
  `SEUD_ASSERT_NR(a_reset_empty, clk_i, !rst_ni |-> !res_valid_o)

endmodule

bind string_escape_utf8_decoder seud_checker u_seud_checker (.*);
